[hdl/edr_pkg.sv]
// Package with the shared types and constants of the distance row engine.
`timescale 1ns / 1ps

package edr_pkg;

    localparam int MAX_CLIENTS = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int COORD_W     = 16;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int OUT_W       = 33;
    localparam int ROOT_W      = 33;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 4;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int QUOT_W      = 65;
    localparam int DIV_STAGES  = QUOT_W;
    localparam int DREM_W      = SUM_W + 1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_ROW   = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   client_index;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic [OUT_W-1:0] distance;
        logic [OUT_W-1:0] visibility;
        logic             last;
    } result_t;

    // Information that rides along with one row entry through the arithmetic units.
    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic             last;
        logic             zero;
        logic [OUT_W-1:0] aux;
    } side_t;

endpackage

[hdl/edr_coord_ram.sv]
// Coordinate store: one write port and one registered read port.
`timescale 1ns / 1ps

module edr_coord_ram
    import edr_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [SQ_W-1:0]      wdata,
    input  logic [IDX_W-1:0]     raddr,
    output logic [SQ_W-1:0]      rdata
);

    logic [SQ_W-1:0] mem [MAX_CLIENTS];
    logic [SQ_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/edr_isqrt.sv]
// Pipelined integer square root, one root bit resolved per stage.
`timescale 1ns / 1ps

module edr_isqrt
    import edr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    input  logic [RAD_W-1:0]  radicand,
    input  side_t             src_side,
    output logic              root_valid,
    output logic [ROOT_W-1:0] root,
    output side_t             root_side
);

    logic              vld_reg  [SQRT_STAGES];
    logic [RAD_W-1:0]  rad_reg  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    side_t             side_reg [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        logic              vld_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        side_t             side_in;
        logic [REM_W-1:0]  rem_try;
        logic [REM_W-1:0]  trial;

        if (s == 0)
        begin : g_first
            assign vld_in  = src_valid;
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = src_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[s-1];
            assign rad_in  = rad_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // Bring down the next two radicand bits and try appending a one to the root.
        assign rem_try = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial   = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[s]  <= {rad_in[RAD_W-3:0], 2'b00};
            side_reg[s] <= side_in;
            if (rem_try >= trial)
            begin
                rem_reg[s]  <= rem_try - trial;
                root_reg[s] <= {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s]  <= rem_try;
                root_reg[s] <= {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root_valid = vld_reg[SQRT_STAGES-1];
    assign root       = root_reg[SQRT_STAGES-1];
    assign root_side  = side_reg[SQRT_STAGES-1];

endmodule

[hdl/edr_recip_div.sv]
// Pipelined restoring divider that forms floor(2^64 / S), one quotient bit per stage.
`timescale 1ns / 1ps

module edr_recip_div
    import edr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    input  logic [SUM_W-1:0]  divisor,
    input  side_t             src_side,
    output logic              quot_valid,
    output logic [QUOT_W-1:0] quotient,
    output side_t             quot_side
);

    logic              vld_reg  [DIV_STAGES];
    logic [SUM_W-1:0]  dvs_reg  [DIV_STAGES];
    logic [SUM_W-1:0]  rem_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_reg [DIV_STAGES];
    side_t             side_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic              vld_in;
        logic [SUM_W-1:0]  dvs_in;
        logic [SUM_W-1:0]  rem_in;
        logic [QUOT_W-1:0] quot_in;
        side_t             side_in;
        logic [DREM_W-1:0] rem_try;
        logic [DREM_W-1:0] rem_sub;

        if (s == 0)
        begin : g_first
            assign vld_in  = src_valid;
            assign dvs_in  = divisor;
            assign rem_in  = '0;
            assign quot_in = '0;
            assign side_in = src_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[s-1];
            assign dvs_in  = dvs_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign quot_in = quot_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // The dividend is a single one in its top bit, so only the first stage brings in a one.
        assign rem_try = {rem_in, (s == 0) ? 1'b1 : 1'b0};
        assign rem_sub = rem_try - {1'b0, dvs_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dvs_reg[s]  <= dvs_in;
            side_reg[s] <= side_in;
            if (rem_try >= {1'b0, dvs_in})
            begin
                rem_reg[s]  <= rem_sub[SUM_W-1:0];
                quot_reg[s] <= {quot_in[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s]  <= rem_try[SUM_W-1:0];
                quot_reg[s] <= {quot_in[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign quot_valid = vld_reg[DIV_STAGES-1];
    assign quotient   = quot_reg[DIV_STAGES-1];
    assign quot_side  = side_reg[DIV_STAGES-1];

endmodule

[hdl/euclidean_distance_row_engine_unit.sv]
// Top level of the distance row engine: sequencer, coordinate store and arithmetic pipeline.
`timescale 1ns / 1ps

// A write transaction (mode 0) stores one client's coordinates and produces no result.
// A row transaction (mode 1) reads the origin in its acceptance cycle and then keeps
// busy high while it reads client_count destinations, one per cycle, from the single
// read port of the coordinate store, which sets the row rate of one entry per clock.
// Each entry then flows through a pipeline of four front stages, a 33-stage square root
// for the distance, a 65-stage divider for 2^64/S, a 33-stage square root for the
// visibility and an output register, so results appear on result with a one-cycle
// result_valid strobe, one per clock, in destination order, the final one carrying
// last. The receiver cannot hold results off and none is needed: the pipeline never
// stalls. A new transaction may be started as soon as busy falls, even while earlier
// results are still in flight. Write client_count through cfg_we and cfg_data only
// while no row is in progress; 0 acts as 1 and values above 64 act as 64.

module euclidean_distance_row_engine_unit
    import edr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             result_valid,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_ROW  = 2'b10
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic             last;
        logic             same;
    } meta_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  dest_reg, dest_next;
    logic [IDX_W-1:0]  org_idx_reg, org_idx_next;
    logic              accept;
    logic              row_last;
    logic [IDX_W-1:0]  raddr;
    logic [SQ_W-1:0]   rdata;

    // Front pipeline registers.
    logic              org_pend_reg;
    logic [SQ_W-1:0]   org_reg;
    logic              rd_vld_reg;
    meta_t             rd_meta_reg;
    logic              d_vld_reg;
    meta_t             d_meta_reg;
    logic [COORD_W-1:0] dx_reg, dy_reg;
    logic              sq_vld_reg;
    meta_t             sq_meta_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg;
    logic              s_vld_reg;
    side_t             s_side_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic [COORD_W-1:0] cur_x, cur_y, org_x, org_y;
    logic [SUM_W-1:0]   sum_next;

    logic              dist_vld;
    logic [ROOT_W-1:0] dist_root;
    side_t             dist_side;
    side_t             div_side_in;
    logic              quot_vld;
    logic [QUOT_W-1:0] quot;
    side_t             quot_side;
    logic              vis_vld;
    logic [ROOT_W-1:0] vis_root;
    side_t             vis_side;

    logic              result_valid_reg;
    result_t           result_reg;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign row_last = ({1'b0, dest_reg} + CNT_W'(1)) == len_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(MAX_CLIENTS);
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    // Row sequencer.
    always_comb
    begin
        state_next   = state_reg;
        len_next     = len_reg;
        dest_next    = dest_reg;
        org_idx_next = org_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.mode == MODE_ROW))
                begin
                    state_next   = ST_ROW;
                    dest_next    = '0;
                    org_idx_next = item.client_index;
                    if (count_reg == '0)
                    begin
                        len_next = CNT_W'(1);
                    end
                    else if (count_reg > CNT_W'(MAX_CLIENTS))
                    begin
                        len_next = CNT_W'(MAX_CLIENTS);
                    end
                    else
                    begin
                        len_next = count_reg;
                    end
                end
            end
            ST_ROW:
            begin
                dest_next = dest_reg + IDX_W'(1);
                if (row_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        dest_reg    <= dest_next;
        org_idx_reg <= org_idx_next;
    end

    // The origin is read in the acceptance cycle, the destinations in the cycles after it.
    assign raddr = (state_reg == ST_ROW) ? dest_reg : item.client_index;

    edr_coord_ram u_ram (
        .clk   (clk),
        .we    (accept && (item.mode == MODE_WRITE)),
        .waddr (item.client_index),
        .wdata ({item.coord_x, item.coord_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_pend_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            d_vld_reg    <= 1'b0;
            sq_vld_reg   <= 1'b0;
            s_vld_reg    <= 1'b0;
        end
        else
        begin
            org_pend_reg <= accept && (item.mode == MODE_ROW);
            rd_vld_reg   <= (state_reg == ST_ROW);
            d_vld_reg    <= rd_vld_reg;
            sq_vld_reg   <= d_vld_reg;
            s_vld_reg    <= sq_vld_reg;
        end
    end

    assign cur_x = rdata[SQ_W-1:COORD_W];
    assign cur_y = rdata[COORD_W-1:0];
    assign org_x = org_reg[SQ_W-1:COORD_W];
    assign org_y = org_reg[COORD_W-1:0];
    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk)
    begin
        if (org_pend_reg)
        begin
            org_reg <= rdata;
        end
        rd_meta_reg.dest_index <= dest_reg;
        rd_meta_reg.last       <= row_last;
        rd_meta_reg.same       <= (dest_reg == org_idx_reg);

        d_meta_reg <= rd_meta_reg;
        dx_reg     <= (cur_x >= org_x) ? (cur_x - org_x) : (org_x - cur_x);
        dy_reg     <= (cur_y >= org_y) ? (cur_y - org_y) : (org_y - cur_y);

        sq_meta_reg <= d_meta_reg;
        sqx_reg     <= dx_reg * dx_reg;
        sqy_reg     <= dy_reg * dy_reg;

        s_side_reg.dest_index <= sq_meta_reg.dest_index;
        s_side_reg.last       <= sq_meta_reg.last;
        s_side_reg.zero       <= sq_meta_reg.same || (sum_next == '0);
        s_side_reg.aux        <= sum_next;
        sum_reg               <= sum_next;
    end

    // Distance: floor(sqrt(S * 2^32)). The side word carries S on to the divider.
    edr_isqrt u_dist_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (s_vld_reg),
        .radicand   ({1'b0, sum_reg, 32'b0}),
        .src_side   (s_side_reg),
        .root_valid (dist_vld),
        .root       (dist_root),
        .root_side  (dist_side)
    );

    // From here on the side word carries the finished distance.
    always_comb
    begin
        div_side_in     = dist_side;
        div_side_in.aux = dist_root;
    end

    edr_recip_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (dist_vld),
        .divisor    (dist_side.aux),
        .src_side   (div_side_in),
        .quot_valid (quot_vld),
        .quotient   (quot),
        .quot_side  (quot_side)
    );

    // Visibility: floor(sqrt(floor(2^64 / S))), which equals floor(2^32 / sqrt(S)).
    edr_isqrt u_vis_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (quot_vld),
        .radicand   ({1'b0, quot}),
        .src_side   (quot_side),
        .root_valid (vis_vld),
        .root       (vis_root),
        .root_side  (vis_side)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= vis_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.dest_index <= vis_side.dest_index;
        result_reg.last       <= vis_side.last;
        result_reg.distance   <= vis_side.zero ? '0 : vis_side.aux;
        result_reg.visibility <= vis_side.zero ? '0 : vis_root;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[sim/tb_euclidean_distance_row_engine_unit.sv]
// Self-checking testbench for the Euclidean distance row engine.
`timescale 1ns / 1ps

// The testbench first fills the whole coordinate table, so that no row can ever read
// an entry that was never written. It then runs directed rows on chosen coordinates and
// random write and row traffic under several client counts, the extremes among them.
// A predictor in this file keeps its own copy of the table and of the client count.
// For every accepted row transaction it computes the expected entries in destination
// order. A monitor checks each result strobe against the oldest expected entry.

module tb_euclidean_distance_row_engine_unit;
    import edr_pkg::*;

    // Long enough for row entries to get through the pipeline, so this covers the tail.
    localparam int PIPE_TAIL   = 160;
    localparam int QUIET_LIMIT = 3000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    item_t            item;
    logic             result_valid;
    result_t          result;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_data;

    // Model state: the coordinate table and the client count as last written.
    logic [COORD_W-1:0] x_store [MAX_CLIENTS];
    logic [COORD_W-1:0] y_store [MAX_CLIENTS];
    logic [CNT_W-1:0]   count_reg;

    result_t row_entries_q[$];
    int      error_count;
    int      quiet_cycles;
    bit      no_idle;

    euclidean_distance_row_engine_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Distance: the largest D with D*D <= S * 2^32, found bit by bit.
    function automatic logic [OUT_W-1:0] root_q16(logic [SUM_W-1:0] s);
        logic [127:0]     target;
        logic [127:0]     trial;
        logic [OUT_W-1:0] d;
        target = {95'b0, s} << 32;
        d      = '0;
        for (int b = OUT_W - 1; b >= 0; b--)
        begin
            trial = {95'b0, d | (33'b1 << b)};
            if (trial * trial <= target)
                d = trial[OUT_W-1:0];
        end
        return d;
    endfunction

    // Visibility: the largest V with V*V*S <= 2^64; this gives 2^32 when S is 1.
    function automatic logic [OUT_W-1:0] recip_q32(logic [SUM_W-1:0] s);
        logic [127:0]     trial;
        logic [OUT_W-1:0] v;
        v = '0;
        for (int b = OUT_W - 1; b >= 0; b--)
        begin
            trial = {95'b0, v | (33'b1 << b)};
            if (trial * trial * {95'b0, s} <= (128'b1 << 64))
                v = trial[OUT_W-1:0];
        end
        return v;
    endfunction

    // Applies one accepted transaction to the model and queues the entries it causes.
    task automatic predict_transaction(item_t it);
        int                 n;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [SQ_W-1:0]    sqx;
        logic [SQ_W-1:0]    sqy;
        logic [SUM_W-1:0]   s;
        result_t            r;
        if (it.mode == MODE_WRITE)
        begin
            x_store[it.client_index] = it.coord_x;
            y_store[it.client_index] = it.coord_y;
        end
        else
        begin
            // A count of zero acts as one; anything above the table size acts as 64.
            n = (count_reg == 0) ? 1 : (count_reg > MAX_CLIENTS) ? MAX_CLIENTS : count_reg;
            for (int j = 0; j < n; j++)
            begin
                dx = (x_store[j] >= x_store[it.client_index])
                     ? x_store[j] - x_store[it.client_index]
                     : x_store[it.client_index] - x_store[j];
                dy = (y_store[j] >= y_store[it.client_index])
                     ? y_store[j] - y_store[it.client_index]
                     : y_store[it.client_index] - y_store[j];
                sqx = dx * dx;
                sqy = dy * dy;
                s   = {1'b0, sqx} + {1'b0, sqy};
                r.dest_index = j[IDX_W-1:0];
                r.last       = (j == n - 1);
                // The same client or coincident clients give zero for both values.
                if (j == it.client_index || s == 0)
                begin
                    r.distance   = '0;
                    r.visibility = '0;
                end
                else
                begin
                    r.distance   = root_q16(s);
                    r.visibility = recip_q32(s);
                end
                row_entries_q.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Checks every result strobe against the oldest expected row entry.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            quiet_cycles = 0;
            if (row_entries_q.size() == 0)
            begin
                report_mismatch("unexpected result count", 1, 0);
            end
            else
            begin
                result_t want;
                want = row_entries_q.pop_front();
                if (result.dest_index !== want.dest_index)
                    report_mismatch("dest_index", result.dest_index, want.dest_index);
                if (result.distance !== want.distance)
                    report_mismatch("distance", result.distance, want.distance);
                if (result.visibility !== want.visibility)
                    report_mismatch("visibility", result.visibility, want.visibility);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
            end
        end
    end

    // Watchdog: the run ends if nothing is accepted and no result arrives for too long.
    always @(posedge clk)
    begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired at %0t", $realtime);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one transaction. It is entered and left at a falling edge; start stays high
    // afterwards so that back-to-back transactions keep it high without a glitch.
    task automatic send_item(item_t it);
        bit taken;
        if (!no_idle && $urandom_range(99) < 28)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            if (!busy)
            begin
                taken        = 1;
                quiet_cycles = 0;
                predict_transaction(it);
            end
            @(negedge clk);
        end
    endtask

    // Stops sending and waits until every expected entry has arrived and the pipe is empty.
    task automatic drain_rows();
        start <= 1'b0;
        while (row_entries_q.size() != 0)
            @(negedge clk);
        repeat (PIPE_TAIL) @(negedge clk);
    endtask

    task automatic set_client_count(logic [CNT_W-1:0] value);
        drain_rows();
        cfg_we    <= 1'b1;
        cfg_data  <= value;
        count_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        quiet_cycles = 0;
    endtask

    function automatic item_t make_write(int idx, int x, int y);
        item_t it;
        it.mode         = MODE_WRITE;
        it.client_index = idx[IDX_W-1:0];
        it.coord_x      = x[COORD_W-1:0];
        it.coord_y      = y[COORD_W-1:0];
        return it;
    endfunction

    function automatic item_t make_row(int idx);
        item_t it;
        it.mode         = MODE_ROW;
        it.client_index = idx[IDX_W-1:0];
        it.coord_x      = COORD_W'($urandom());
        it.coord_y      = COORD_W'($urandom());
        return it;
    endfunction

    // Every entry gets a value before any row is asked for. Clients 0 and 2 coincide,
    // client 1 sits at the far corner and client 3 is one unit from client 0.
    task automatic test_fill_table();
        send_item(make_write(0, 0, 0));
        send_item(make_write(1, 16'hFFFF, 16'hFFFF));
        send_item(make_write(2, 0, 0));
        send_item(make_write(3, 1, 0));
        for (int i = 4; i < MAX_CLIENTS; i++)
            send_item(make_write(i, $urandom(), $urandom()));
    endtask

    // Rows from the corners, the unit neighbor and the last client at the reset count.
    task automatic test_directed_rows();
        send_item(make_row(0));
        send_item(make_row(1));
        send_item(make_row(3));
        send_item(make_row(MAX_CLIENTS - 1));
        send_item(make_write(5, 16'hFFFF, 0));
        send_item(make_row(5));
    endtask

    // Short rows, including a zero count and an origin past the count, and a full row under an oversize count.
    task automatic test_client_count_settings();
        set_client_count(0);
        send_item(make_row(0));
        send_item(make_row(40));
        set_client_count(1);
        send_item(make_row(0));
        set_client_count(2);
        send_item(make_row(1));
        send_item(make_row(63));
        set_client_count(7'h7F);
        send_item(make_row(2));
    endtask

    // Random writes and rows in phases with different counts; one phase runs without gaps.
    task automatic test_random_traffic();
        int      counts[6];
        int      src;
        item_t   it;
        counts = '{64, 1, $urandom_range(3, 63), 0, 127, $urandom_range(2, 64)};
        for (int p = 0; p < 6; p++)
        begin
            set_client_count(counts[p][CNT_W-1:0]);
            no_idle = (p == 2);
            for (int k = 0; k < 80; k++)
            begin
                if ($urandom_range(99) < 40)
                begin
                    case ($urandom_range(3))
                        0: it = make_write($urandom_range(63), 0, 16'hFFFF);
                        1:
                        begin
                            // Copy another client so coincident pairs keep turning up.
                            src = $urandom_range(63);
                            it  = make_write($urandom_range(63), x_store[src], y_store[src]);
                        end
                        default: it = make_write($urandom_range(63), $urandom(), $urandom());
                    endcase
                end
                else
                    it = make_row($urandom_range(63));
                send_item(it);
            end
        end
        no_idle = 0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        count_reg    = 7'd64;
        error_count  = 0;
        quiet_cycles = 0;
        no_idle      = 0;
        for (int i = 0; i < MAX_CLIENTS; i++)
        begin
            x_store[i] = '0;
            y_store[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_fill_table();
        test_directed_rows();
        test_client_count_settings();
        test_random_traffic();
        drain_rows();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
